>>> sv/u8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
`default_nettype none
package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int REM_W  = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CONT_PAYLOAD  = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] LEAD2_PAYLOAD = 8'b0001_1111;
  localparam logic [BYTE_W-1:0] LEAD3_PAYLOAD = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] LEAD4_PAYLOAD = 8'b0000_0111;

  localparam logic [REM_W-1:0] REM_NONE = 2'd0;
  localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
  localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
  localparam logic [REM_W-1:0] REM_THREE = 2'd3;

  localparam logic [CP_W-1:0] CP_STRAY = 21'd1;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_LEAD,
    OP_CONT,
    OP_STRAY
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [REM_W-1:0]  rem;
    logic [BYTE_W-1:0] data;
  } u8d_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> sv/utf8_byte_stream_decoder_core.sv
// Top level of the UTF-8 byte stream decoder: front, queue and back.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_byte_req[7:0]
//   out_     output     out_valid/out_stall out_code_point[20:0], out_bad_lead
//
// One byte per clock is accepted unless the queue is full; a result enters the
// output register when its byte is popped from the queue, where each byte is first stored.
// The front stalls only when the two-entry queue is full; the back drains the
// queue whenever the output register is empty or being read.
// Synchronous active-low reset empties the queue, closes any open sequence and
// drops a pending result.
`default_nettype none
module utf8_byte_stream_decoder_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [u8d_pkg::BYTE_W-1:0] in_byte_req,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [u8d_pkg::CP_W-1:0]       out_code_point,
  output logic                           out_bad_lead
);
  import u8d_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  u8d_op_t push_op;
  u8d_op_t pop_op;

  u8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte_req (in_byte_req),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_op        (push_op)
  );

  u8d_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .stat    (q_stat)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_op           (pop_op),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_bad_lead   (out_bad_lead)
  );

`ifndef SYNTH
  a_stray_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_lead) |-> (out_code_point == CP_STRAY))
    else $error("stray continuation result without code point one");

  a_q_stat : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_reset_drop : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

>>> sv/u8d_front.sv
// Front end: accepts bytes, tracks sequence length and classifies each byte.
`default_nettype none
module u8d_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [u8d_pkg::BYTE_W-1:0] in_byte_req,
  input  wire u8d_pkg::q_stat_t          q_stat,
  output logic                           q_push,
  output u8d_pkg::u8d_op_t               q_op
);
  import u8d_pkg::*;

  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W-1:0] rem_cls;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_op.data = in_byte_req;
    q_op.rem  = REM_NONE;
    q_op.kind = OP_STRAY;
    rem_cls   = REM_NONE;
    if (rem_r != REM_NONE) begin
      q_op.kind = OP_CONT;
      q_op.rem  = rem_r;
      rem_cls   = rem_r - REM_ONE;
    end else if (!in_byte_req[7]) begin
      q_op.kind = OP_CHAR;
    end else if (in_byte_req[7:4] == 4'hF) begin
      q_op.kind = OP_LEAD;
      q_op.rem  = REM_THREE;
      rem_cls   = REM_THREE;
    end else if (in_byte_req[7:5] == 3'b111) begin
      q_op.kind = OP_LEAD;
      q_op.rem  = REM_TWO;
      rem_cls   = REM_TWO;
    end else if (in_byte_req[7:6] == 2'b11) begin
      q_op.kind = OP_LEAD;
      q_op.rem  = REM_ONE;
      rem_cls   = REM_ONE;
    end
  end

  assign rem_nxt = q_push ? rem_cls : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= REM_NONE;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/u8d_queue.sv
// Short queue of classified bytes between front and back.
`default_nettype none
module u8d_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire u8d_pkg::u8d_op_t push_op,
  input  wire logic             pop,
  output u8d_pkg::u8d_op_t      pop_op,
  output u8d_pkg::q_stat_t      stat
);
  import u8d_pkg::*;

  u8d_op_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_op     = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/u8d_back.sv
// Back end: gathers payload bits and drives the code point output register.
`default_nettype none
module u8d_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire u8d_pkg::q_stat_t         q_stat,
  input  wire u8d_pkg::u8d_op_t         q_op,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic                          out_bad_lead
);
  import u8d_pkg::*;

  logic [CP_W-1:0] partial_r;
  logic [CP_W-1:0] partial_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [CP_W-1:0] cp_r;
  logic [CP_W-1:0] cp_nxt;
  logic            bad_r;
  logic            bad_nxt;
  logic            emit;
  logic [CP_W-1:0] emit_cp;
  logic            emit_bad;
  logic [CP_W-1:0] lead_bits;
  logic [CP_W-1:0] cont_bits;
  logic [CP_W-1:0] cont_sum;

  assign q_pop = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    lead_bits = '0;
    cont_bits = '0;
    case (q_op.rem)
      REM_THREE: begin
        lead_bits = CP_W'(q_op.data & LEAD4_PAYLOAD) << 18;
        cont_bits = CP_W'(q_op.data & CONT_PAYLOAD) << 12;
      end
      REM_TWO: begin
        lead_bits = CP_W'(q_op.data & LEAD3_PAYLOAD) << 12;
        cont_bits = CP_W'(q_op.data & CONT_PAYLOAD) << 6;
      end
      REM_ONE: begin
        lead_bits = CP_W'(q_op.data & LEAD2_PAYLOAD) << 6;
        cont_bits = CP_W'(q_op.data & CONT_PAYLOAD);
      end
      default: begin
        lead_bits = '0;
        cont_bits = '0;
      end
    endcase
  end

  assign cont_sum = partial_r | cont_bits;

  always_comb begin
    emit        = 1'b0;
    emit_cp     = '0;
    emit_bad    = 1'b0;
    partial_nxt = partial_r;
    case (q_op.kind)
      OP_CHAR: begin
        emit    = 1'b1;
        emit_cp = CP_W'(q_op.data);
      end
      OP_LEAD: begin
        partial_nxt = lead_bits;
      end
      OP_CONT: begin
        partial_nxt = cont_sum;
        emit        = (q_op.rem == REM_ONE);
        emit_cp     = cont_sum;
      end
      OP_STRAY: begin
        emit     = 1'b1;
        emit_cp  = CP_STRAY;
        emit_bad = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (!q_pop) begin
      partial_nxt = partial_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    cp_nxt        = cp_r;
    bad_nxt       = bad_r;
    if (q_pop) begin
      out_valid_nxt = emit;
      if (emit) begin
        cp_nxt  = emit_cp;
        bad_nxt = emit_bad;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      partial_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      partial_r   <= partial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    bad_r <= bad_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_bad_lead   = bad_r;

endmodule
`default_nettype wire

>>> tb/utf8_byte_stream_decoder_checker.sv
// Checker for the UTF-8 decoder: tracks transfers, predicts code points and compares results.
module utf8_byte_stream_decoder_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte_req,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [u8d_pkg::CP_W-1:0]   out_code_point,
  input  logic                      out_bad_lead,
  output int                        fail_count,
  output int                        pending,
  output int                        bytes_in,
  output int                        points_out,
  output int                        strays_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            bad;
  } code_point_t;

  code_point_t      code_point_q[$];
  logic [REM_W-1:0] seq_left;
  logic [CP_W-1:0]  seq_bits;

  initial begin
    fail_count = 0;
    pending    = 0;
    bytes_in   = 0;
    points_out = 0;
    strays_out = 0;
    seq_left   = REM_NONE;
    seq_bits   = '0;
  end

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [31:0] wide;
    code_point_t cp_item;
    cp_item = '0;
    if (seq_left != REM_NONE) begin
      wide     = 32'(b & CONT_PAYLOAD) << (6 * (int'(seq_left) - 1));
      seq_bits = seq_bits | wide[CP_W-1:0];
      seq_left = seq_left - 1'b1;
      if (seq_left == REM_NONE) begin
        cp_item.cp = seq_bits;
        code_point_q.push_back(cp_item);
      end
    end else if (!b[7]) begin
      cp_item.cp = CP_W'(b);
      code_point_q.push_back(cp_item);
    end else if (b[7:4] == 4'hF) begin
      seq_bits = CP_W'(b & LEAD4_PAYLOAD) << 18;
      seq_left = REM_THREE;
    end else if (b[7:5] == 3'b111) begin
      seq_bits = CP_W'(b & LEAD3_PAYLOAD) << 12;
      seq_left = REM_TWO;
    end else if (b[7:6] == 2'b11) begin
      seq_bits = CP_W'(b & LEAD2_PAYLOAD) << 6;
      seq_left = REM_ONE;
    end else begin
      cp_item.cp  = CP_STRAY;
      cp_item.bad = 1'b1;
      code_point_q.push_back(cp_item);
    end
  endtask

  always @(posedge clk) begin
    code_point_t want;
    if (!rst_n) begin
      code_point_q.delete();
      seq_left = REM_NONE;
      seq_bits = '0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_in++;
        decode_byte(in_byte_req);
      end
      if (out_valid && !out_stall) begin
        points_out++;
        if (out_bad_lead === 1'b1) strays_out++;
        if (code_point_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got cp=%h bad_lead=%b",
                   $time, out_code_point, out_bad_lead);
          fail_count++;
        end else begin
          want = code_point_q.pop_front();
          if (out_code_point !== want.cp) begin
            $display("%0t: code_point mismatch: expected %h, got %h",
                     $time, want.cp, out_code_point);
            fail_count++;
          end
          if (out_bad_lead !== want.bad) begin
            $display("%0t: bad_lead mismatch: expected %b, got %b",
                     $time, want.bad, out_bad_lead);
            fail_count++;
          end
        end
      end
    end
    pending = code_point_q.size();
  end

endmodule

>>> tb/utf8_byte_stream_decoder_core_tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module utf8_byte_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8d_pkg::*;

  localparam int RANDOM_ITEMS   = 1570;
  localparam int QUIET_TAIL     = 200;
  localparam int HOLD_LEN       = 60;
  localparam int PRESS_ITEMS    = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte_req;
  logic              out_valid;
  logic              out_stall;
  logic [CP_W-1:0]   out_code_point;
  logic              out_bad_lead;

  int fail_count;
  int pending;
  int bytes_in;
  int points_out;
  int strays_out;
  int idle_cycles;

  bit quiet;
  bit calm;
  bit press;
  bit hold_req;

  logic [BYTE_W-1:0] corner_bytes [28] = '{
    8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hC2, 8'h41,
    8'hE0, 8'h80, 8'h80, 8'hEF, 8'hFF, 8'hFF, 8'hF0, 8'h80, 8'h80, 8'h80,
    8'hFF, 8'h00, 8'h3F, 8'h7F, 8'hF8, 8'hBF, 8'hC0, 8'hFF
  };

  utf8_byte_stream_decoder_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_bad_lead   (out_bad_lead)
  );

  utf8_byte_stream_decoder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_bad_lead   (out_bad_lead),
    .fail_count     (fail_count),
    .pending        (pending),
    .bytes_in       (bytes_in),
    .points_out     (points_out),
    .strays_out     (strays_out)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && !calm && !press && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int               sent;
    int               segment;
    int               pick;
    int               seq_len;
    bit               pressed;
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] tail_byte;

    sent        = 0;
    segment     = -1;
    pressed     = 1'b0;
    quiet       = 1'b0;
    calm        = 1'b0;
    press       = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte_req = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (sent / 150 != segment) begin
        segment = sent / 150;
        calm    = ($urandom_range(0, 3) == 0);
      end
      if (!pressed && sent >= 700) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        press    = 1'b1;
        repeat (PRESS_ITEMS) begin
          send_byte(BYTE_W'($urandom_range(0, 127)));
          sent++;
        end
        press = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        seq_len = $urandom_range(1, 4);
        case (seq_len)
          1: lead_byte = BYTE_W'($urandom_range(0, 127));
          2: lead_byte = 8'hC0 | BYTE_W'($urandom_range(0, 31));
          3: lead_byte = 8'hE0 | BYTE_W'($urandom_range(0, 15));
          default: lead_byte = 8'hF0 | BYTE_W'($urandom_range(0, 15));
        endcase
        send_byte(lead_byte);
        sent++;
        repeat (seq_len - 1) begin
          if ($urandom_range(0, 7) == 0) tail_byte = BYTE_W'($urandom_range(0, 255));
          else tail_byte = 8'h80 | BYTE_W'($urandom_range(0, 63));
          send_byte(tail_byte);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("run covered %0d bytes and %0d decoded results, %0d of them stray continuations",
             bytes_in, points_out, strays_out);
    $display("mismatches: %0d, results still outstanding: %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
